// File: rtl/scfd_pkg.sv
// Shared types and constants for the serial command frame decoder.
// No dependencies.
package scfd_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = CFG_IDX_W'(1);

	localparam logic [7:0] START_CHAR_RST = 8'd45; // '-'
	localparam logic [7:0] END_CHAR_RST   = 8'd59; // ';'

	localparam logic [7:0] CMD_SPEED  = 8'h76; // 'v'
	localparam logic [7:0] CMD_STOP   = 8'h73; // 's'
	localparam logic [7:0] CMD_LED    = 8'h6C; // 'l'
	localparam logic [7:0] CHAR_ONE   = 8'h31; // '1'
	localparam logic [15:0] DIGIT_ZERO = 16'd48;

	localparam logic [1:0] ACT_SPEED = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_LED   = 2'd2;

	// frame positions that the decode looks at
	localparam int unsigned NUM_KEPT = 9;

	function automatic int unsigned kept_pos(input int unsigned k);
		case (k)
			0: kept_pos = 1;
			1: kept_pos = 3;
			2: kept_pos = 4;
			3: kept_pos = 5;
			4: kept_pos = 6;
			5: kept_pos = 8;
			6: kept_pos = 9;
			7: kept_pos = 10;
			8: kept_pos = 11;
			default: kept_pos = 0;
		endcase
	endfunction

	typedef struct packed {
		logic       close;
		logic [7:0] p1;
		logic [7:0] p3;
		logic [7:0] p4;
		logic [7:0] p5;
		logic [7:0] p6;
		logic [7:0] p8;
		logic [7:0] p9;
		logic [7:0] p10;
		logic [7:0] p11;
	} frame_info_t;

	// three ASCII digits to a value, wrapping at 16 bits
	function automatic logic [15:0] speed_calc(input logic [7:0] h, input logic [7:0] t,
			input logic [7:0] u);
		logic [15:0] dh, dt, du;
		dh = {8'd0, h} - DIGIT_ZERO;
		dt = {8'd0, t} - DIGIT_ZERO;
		du = {8'd0, u} - DIGIT_ZERO;
		speed_calc = dh * 16'd100 + dt * 16'd10 + du;
	endfunction

endpackage

// File: rtl/scfd_frame.sv
// Frame collector: start/end detection, byte count and the kept frame positions.
// Depends on scfd_pkg.
module scfd_frame import scfd_pkg::*; #(
	parameter int unsigned FRAME_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  start_char,
	input  logic [7:0]  end_char,
	output frame_info_t info
);

	localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);

	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       kept_q [NUM_KEPT];

	logic is_start, is_end, room;

	assign is_start = (rx_byte == start_char);
	assign is_end   = (rx_byte == end_char);
	assign room     = (count_q < CNT_W'(FRAME_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (go) begin
			if (!in_frame_q) begin
				if (is_start) begin
					in_frame_q <= 1'b1;
					count_q    <= CNT_W'(1);
				end
			end else if (!is_end && room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				// end of frame, or overflow drops the frame
				in_frame_q <= 1'b0;
				count_q    <= '0;
			end
		end
	end

	for (genvar k = 0; k < NUM_KEPT; k++) begin : g_kept
		always_ff @(posedge clk) begin
			if (go) begin
				if (!in_frame_q) begin
					if (is_start)
						kept_q[k] <= 8'd0;
				end else if (!is_end && room && count_q == CNT_W'(kept_pos(k))) begin
					kept_q[k] <= rx_byte;
				end
			end
		end
	end

	always_comb begin
		info.close = in_frame_q && is_end;
		info.p1    = kept_q[0];
		info.p3    = kept_q[1];
		info.p4    = kept_q[2];
		info.p5    = kept_q[3];
		info.p6    = kept_q[4];
		info.p8    = kept_q[5];
		info.p9    = kept_q[6];
		info.p10   = kept_q[7];
		info.p11   = kept_q[8];
	end

endmodule

// File: rtl/serial_command_frame_decoder.sv
// Serial command frame decoder top level. Depends on scfd_pkg and scfd_frame.
// A word accepted at the input is registered in the input stage, and its result is then registered on out.
// Throughput: one input word per cycle; the output register stalls only
// words that close a frame with a known command.
// Reset: asynchronous, active low; idle, flags cleared, start '-' and end ';'.
module serial_command_frame_decoder import scfd_pkg::*; #(
	parameter int unsigned FRAME_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           action,
	output logic [7:0]           sign_a,
	output logic [7:0]           sign_b,
	output logic [15:0]          speed_a,
	output logic [15:0]          speed_b,
	output logic                 green_on,
	output logic                 red_on
);

	logic [7:0] start_q, end_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       green_q, red_q;
	frame_info_t info;

	logic is_v, is_s, is_l, has_res, s1_go, go;
	logic green_nx, red_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_CHAR_RST;
			end_q   <= END_CHAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_CHAR: start_q <= cfg_data;
				REG_END_CHAR:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	scfd_frame #(.FRAME_MAX(FRAME_MAX)) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.rx_byte    (byte_s1),
		.start_char (start_q),
		.end_char   (end_q),
		.info       (info)
	);

	assign is_v    = (info.p1 == CMD_SPEED);
	assign is_s    = (info.p1 == CMD_STOP);
	assign is_l    = (info.p1 == CMD_LED);
	assign has_res = info.close && (is_v || is_s || is_l);

	// a word with no result never waits on the output side
	assign s1_go    = !has_res || !out_valid || !out_stall;
	assign go       = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;

	assign green_nx = green_q ^ (is_l && info.p3 == CHAR_ONE);
	assign red_nx   = red_q ^ (is_l && info.p5 == CHAR_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			green_q   <= 1'b0;
			red_q     <= 1'b0;
		end else begin
			if (go && has_res) begin
				out_valid <= 1'b1;
				green_q   <= green_nx;
				red_q     <= red_nx;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_res) begin
			green_on <= green_nx;
			red_on   <= red_nx;
			if (is_v) begin
				action  <= ACT_SPEED;
				sign_a  <= info.p3;
				sign_b  <= info.p8;
				speed_a <= speed_calc(info.p4, info.p5, info.p6);
				speed_b <= speed_calc(info.p9, info.p10, info.p11);
			end else begin
				action  <= is_s ? ACT_STOP : ACT_LED;
				sign_a  <= 8'd0;
				sign_b  <= 8'd0;
				speed_a <= 16'd0;
				speed_b <= 16'd0;
			end
		end
	end

endmodule

// File: dv/serial_command_frame_decoder_tb.sv
// Self-checking testbench for serial_command_frame_decoder: directed frames, then
// random well-formed and broken frames under several start/end character settings.
// Depends on scfd_pkg and the decoder RTL.
module serial_command_frame_decoder_tb;
	import scfd_pkg::*;

	localparam int FRAME_MAX = 16;
	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_WORDS = 120;
	localparam int NUM_PHASES = 6;
	localparam logic [7:0] PLUS = 8'h2B;
	localparam logic [7:0] MINUS = 8'h2D;
	localparam logic [7:0] COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  sign_a;
		logic [7:0]  sign_b;
		logic [15:0] speed_a;
		logic [15:0] speed_b;
		logic        green_on;
		logic        red_on;
	} decoded_cmd_t;

	typedef struct {
		string        txt;
		bit           typed;
		decoded_cmd_t res;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           action;
	logic [7:0]           sign_a;
	logic [7:0]           sign_b;
	logic [15:0]          speed_a;
	logic [15:0]          speed_b;
	logic                 green_on;
	logic                 red_on;

	serial_command_frame_decoder #(.FRAME_MAX(FRAME_MAX)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .sign_a(sign_a), .sign_b(sign_b),
		.speed_a(speed_a), .speed_b(speed_b),
		.green_on(green_on), .red_on(red_on)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// frame tracker state
	bit         frm_open = 1'b0;
	int         frm_len = 0;
	logic [7:0] frm_buf [FRAME_MAX];
	bit         led_green = 1'b0;
	bit         led_red = 1'b0;
	logic [7:0] cur_start = START_CHAR_RST;
	logic [7:0] cur_end = END_CHAR_RST;

	decoded_cmd_t pending_cmds [$];
	decoded_cmd_t typed_res;
	bit           typed_on = 1'b0;
	bit           idle_on = 1'b1;
	bit           hold_req = 1'b0;
	int           fails = 0;
	int           live_words = 0;
	int           results_seen = 0;
	int           cycle_cnt = 0;

	dir_row_t dir_rows [16] = '{
		'{";;-;", 1'b0, '0},
		'{"-s;", 1'b1, '{ACT_STOP, 8'h00, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{"-v,+123,-045;", 1'b1, '{ACT_SPEED, PLUS, MINUS, 16'd123, 16'd45, 1'b0, 1'b0}},
		'{"-v,-999,+000;", 1'b1, '{ACT_SPEED, MINUS, PLUS, 16'd999, 16'd0, 1'b0, 1'b0}},
		'{"-v,+123,+456,789;", 1'b1, '{ACT_SPEED, PLUS, PLUS, 16'd123, 16'd456, 1'b0, 1'b0}},
		'{"-v,+123,+456,7890a;-s;", 1'b1, '{ACT_STOP, 8'h00, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{"-l,1,0;", 1'b1, '{ACT_LED, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1, 1'b0}},
		'{"-l,0,1;", 1'b1, '{ACT_LED, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{"-l,1,1;", 1'b1, '{ACT_LED, 8'h00, 8'h00, 16'd0, 16'd0, 1'b0, 1'b0}},
		'{"-l,1-1;", 1'b1, '{ACT_LED, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{"-v,+5;", 1'b0, '0},
		'{"-v,+\377\377\377,-:/@;", 1'b0, '0},
		'{"-q,+123;", 1'b0, '0},
		'{"-l;", 1'b1, '{ACT_LED, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{"--s;", 1'b0, '0},
		'{"abc\377-s;", 1'b1, '{ACT_STOP, 8'h00, 8'h00, 16'd0, 16'd0, 1'b1, 1'b1}}
	};

	// positions past the received length read as zero
	function automatic logic [7:0] frm_at(int i);
		return (i < FRAME_MAX && i < frm_len) ? frm_buf[i] : 8'h00;
	endfunction

	function automatic logic [15:0] digits_at(int p);
		logic [15:0] h, t, u;
		h = 16'(frm_at(p)) - DIGIT_ZERO;
		t = 16'(frm_at(p + 1)) - DIGIT_ZERO;
		u = 16'(frm_at(p + 2)) - DIGIT_ZERO;
		return 16'(h * 16'd100 + t * 16'd10 + u);
	endfunction

	task automatic decode_word(input logic [7:0] b, output bit used, output bit got,
			output decoded_cmd_t r);
		used = 1'b1;
		got = 1'b0;
		r = '0;
		if (!frm_open) begin
			used = (b == cur_start);
			if (used) begin
				foreach (frm_buf[i]) frm_buf[i] = 8'h00;
				frm_buf[0] = b;
				frm_len = 1;
				frm_open = 1'b1;
			end
		end else if (b != cur_end) begin
			if (frm_len < FRAME_MAX) begin
				frm_buf[frm_len] = b;
				frm_len++;
			end else begin
				// over-long frame is dropped with this word
				frm_open = 1'b0;
				frm_len = 0;
			end
		end else begin
			frm_open = 1'b0;
			got = 1'b1;
			case (frm_at(1))
				CMD_SPEED: begin
					r.action = ACT_SPEED;
					r.sign_a = frm_at(3);
					r.sign_b = frm_at(8);
					r.speed_a = digits_at(4);
					r.speed_b = digits_at(9);
				end
				CMD_STOP: r.action = ACT_STOP;
				CMD_LED: begin
					if (frm_at(3) == CHAR_ONE) led_green = !led_green;
					if (frm_at(5) == CHAR_ONE) led_red = !led_red;
					r.action = ACT_LED;
				end
				default: got = 1'b0;
			endcase
			r.green_on = led_green;
			r.red_on = led_red;
			frm_len = 0;
		end
	endtask

	task automatic cmp(input string name, input logic [15:0] want_v, input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		decoded_cmd_t want, res;
		bit w_used, w_got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_cmds.size() == 0) begin
					$error("result with nothing pending: action %0d", action);
					fails++;
				end else begin
					want = pending_cmds.pop_front();
					cmp("action", 16'(want.action), 16'(action));
					cmp("sign_a", 16'(want.sign_a), 16'(sign_a));
					cmp("sign_b", 16'(want.sign_b), 16'(sign_b));
					cmp("speed_a", want.speed_a, speed_a);
					cmp("speed_b", want.speed_b, speed_b);
					cmp("green_on", 16'(want.green_on), 16'(green_on));
					cmp("red_on", 16'(want.red_on), 16'(red_on));
					results_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				decode_word(rx_byte, w_used, w_got, res);
				if (w_used) live_words++;
				if (w_got) pending_cmds.push_back(typed_on ? typed_res : res);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("serial_command_frame_decoder_tb: errors");
			$finish;
		end
	end

	// output side: random stall bursts, plus one long hold when asked
	initial begin : out_side
		int burst_left, hold_left;
		bit nxt;
		burst_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				nxt = 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 13) - 1;
				nxt = 1'b1;
			end else begin
				nxt = 1'b0;
			end
			out_stall <= nxt;
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [7:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic offer_frame();
		logic [7:0] fq [$];
		int kind, cut;
		kind = $urandom_range(0, 99);
		fq.push_back(cur_start);
		if (kind < 35) begin
			fq.push_back(CMD_SPEED);
			for (int w = 0; w < 2; w++) begin
				fq.push_back(COMMA);
				fq.push_back($urandom_range(0, 1) ? PLUS : MINUS);
				repeat (3) fq.push_back(($urandom_range(0, 9) != 0) ?
						CHAR_ZERO + 8'($urandom_range(0, 9)) : 8'($urandom));
			end
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(2, 11);
				while (fq.size() > cut) void'(fq.pop_back());
			end
		end else if (kind < 50) begin
			fq.push_back(CMD_STOP);
			repeat ($urandom_range(0, 3)) fq.push_back(8'($urandom));
		end else if (kind < 70) begin
			fq.push_back(CMD_LED);
			fq.push_back(COMMA);
			fq.push_back(CHAR_ZERO + 8'($urandom_range(0, 1)));
			fq.push_back(COMMA);
			fq.push_back(CHAR_ZERO + 8'($urandom_range(0, 1)));
		end else if (kind < 78) begin
			// around the length limit, mostly past it
			repeat ($urandom_range(14, 20)) fq.push_back(8'($urandom));
		end else if (kind < 88) begin
			repeat ($urandom_range(1, 6)) fq.push_back(8'($urandom));
		end else begin
			fq.delete();
			repeat ($urandom_range(1, 6)) fq.push_back(8'($urandom));
		end
		if (kind < 88) begin
			// keep the body from closing the frame early
			for (int k = 1; k < fq.size(); k++)
				if (fq[k] == cur_end) fq[k] ^= 8'h01;
			if ($urandom_range(0, 19) != 0) fq.push_back(cur_end);
		end
		foreach (fq[k]) send_word(fq[k]);
	endtask

	// wait for the block to go quiet, then load both characters
	task automatic set_chars(input logic [7:0] s_ch, input logic [7:0] e_ch);
		in_valid <= 1'b0;
		wait (pending_cmds.size() == 0);
		repeat (6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_START_CHAR;
		cfg_data <= s_ch;
		@(negedge clk);
		cfg_index <= REG_END_CHAR;
		cfg_data <= e_ch;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_start = s_ch;
		cur_end = e_ch;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] s_ch, e_ch;
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_CHAR;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			typed_on = dir_rows[r].typed;
			typed_res = dir_rows[r].res;
			for (int k = 0; k < dir_rows[r].txt.len(); k++) send_word(dir_rows[r].txt[k]);
			typed_on = 1'b0;
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: {s_ch, e_ch} = {START_CHAR_RST, END_CHAR_RST};
				1: {s_ch, e_ch} = {8'h00, 8'hFF};
				2: {s_ch, e_ch} = {8'hFF, 8'h00};
				3: {s_ch, e_ch} = {8'h23, 8'h23};
				4: {s_ch, e_ch} = {8'($urandom), 8'($urandom)};
				default: {s_ch, e_ch} = {START_CHAR_RST, END_CHAR_RST};
			endcase
			set_chars(s_ch, e_ch);
			if (p == 0) hold_req = 1'b1;
			if (p == NUM_PHASES - 1) idle_on = 1'b0;
			target = live_words + PHASE_WORDS;
			while (live_words < target) offer_frame();
		end

		in_valid <= 1'b0;
		wait (pending_cmds.size() == 0);
		repeat (8) @(posedge clk);
		$display("covered %0d frame words and %0d decoded commands over %0d character settings,",
				live_words, results_seen, NUM_PHASES);
		$display("with random stalls on both sides and one long output hold");
		if (fails == 0) begin
			$display("serial_command_frame_decoder_tb: clean");
		end else begin
			$display("serial_command_frame_decoder_tb: errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/scfd_pkg.sv
rtl/scfd_frame.sv
rtl/serial_command_frame_decoder.sv
dv/serial_command_frame_decoder_tb.sv
